// ===== rtl/core/hmcm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmcm_pkg: shared types and constants for the HSV colour mask
// Widths, register map, reset values and the fixed S/V minimums.
// ----------------------------------------------------------------------------
package hmcm_pkg;

  localparam int PIX_W      = 8;
  localparam int HUE_W      = 8;
  localparam int QUO_W      = 8;   // both quotients fit in 8 bits
  localparam int S_NUM_W    = 16;  // d*255 + v/2 <= 65152
  localparam int S_DEN_W    = 8;
  localparam int H_NUM_W    = 17;  // 2x + d <= 92055
  localparam int H_DEN_W    = 9;   // 2d
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STAGES = QUO_W / 2;       // two quotient bits a stage
  localparam int PIPE_LATENCY = DIV_STAGES + 3;

  // Fixed red band edges
  localparam logic [HUE_W-1:0] RED_BAND_ONE_FLOOR   = 8'd0;
  localparam logic [HUE_W-1:0] RED_BAND_TWO_CEILING = 8'd180;

  // Saturation / value minimums
  localparam logic [PIX_W-1:0] GREEN_S_MIN  = 8'd50;
  localparam logic [PIX_W-1:0] GREEN_V_MIN  = 8'd50;
  localparam logic [PIX_W-1:0] YELLOW_S_MIN = 8'd100;
  localparam logic [PIX_W-1:0] YELLOW_V_MIN = 8'd100;
  localparam logic [PIX_W-1:0] RED_S_MIN    = 8'd120;
  localparam logic [PIX_W-1:0] RED_V_MIN    = 8'd70;
  localparam logic [PIX_W-1:0] BLUE_S_MIN   = 8'd150;
  localparam logic [PIX_W-1:0] BLUE_V_MIN   = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GREEN_LO   = 3'd0,
    REG_GREEN_HI   = 3'd1,
    REG_YELLOW_LO  = 3'd2,
    REG_YELLOW_HI  = 3'd3,
    REG_RED_ONE_HI = 3'd4,
    REG_RED_TWO_LO = 3'd5,
    REG_BLUE_LO    = 3'd6,
    REG_BLUE_HI    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [HUE_W-1:0] green_lo;
    logic [HUE_W-1:0] green_hi;
    logic [HUE_W-1:0] yellow_lo;
    logic [HUE_W-1:0] yellow_hi;
    logic [HUE_W-1:0] red_one_hi;
    logic [HUE_W-1:0] red_two_lo;
    logic [HUE_W-1:0] blue_lo;
    logic [HUE_W-1:0] blue_hi;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    green_lo:   8'd35,
    green_hi:   8'd85,
    yellow_lo:  8'd20,
    yellow_hi:  8'd30,
    red_one_hi: 8'd10,
    red_two_lo: 8'd170,
    blue_lo:    8'd100,
    blue_hi:    8'd140
  };

  // Pixel and value that ride alongside the dividers
  typedef struct packed {
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] v;
  } side_t;

  // Divider operands and sideband out of the front end
  typedef struct packed {
    logic [S_NUM_W-1:0] s_num;
    logic [S_DEN_W-1:0] s_den;
    logic [H_NUM_W-1:0] h_num;
    logic [H_DEN_W-1:0] h_den;
    side_t              side;
  } prep_t;

endpackage
`default_nettype wire

// ===== rtl/core/hmcm_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmcm_prep: HSV front end
// Two stages: max/min/chroma, then the S and H dividend/divisor pairs.
// ----------------------------------------------------------------------------
module hmcm_prep
  import hmcm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [PIX_W-1:0] blue,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] red,
  output logic                  out_valid,
  output prep_t                 out_data
);

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  // stage 1
  logic             p1_valid;
  logic [PIX_W-1:0] p1_b, p1_g, p1_r, p1_mx, p1_d;
  max_sel_t         p1_sel;

  logic [PIX_W-1:0] mx, mn;
  max_sel_t         sel;

  always_comb begin
    mx = blue;
    mn = blue;
    if (green > mx) mx = green;
    if (red > mx) mx = red;
    if (green < mn) mn = green;
    if (red < mn) mn = red;
    if (mx == red) begin
      sel = MAX_RED;
    end else if (mx == green) begin
      sel = MAX_GREEN;
    end else begin
      sel = MAX_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_b   <= blue;
    p1_g   <= green;
    p1_r   <= red;
    p1_mx  <= mx;
    p1_d   <= mx - mn;
    p1_sel <= sel;
  end

  // stage 2: x = base*d + 30*n; dividend 2x+d, or with 360d added when x < 0
  logic signed [18:0] dd, nn, x, na, nb;
  prep_t              nxt;

  always_comb begin
    dd = $signed({11'b0, p1_d});
    case (p1_sel)
      MAX_RED: begin
        nn = $signed({11'b0, p1_g}) - $signed({11'b0, p1_b});
        x  = nn * 19'sd30;
        na = dd + nn * 19'sd60;
        nb = dd * 19'sd361 + nn * 19'sd60;
      end
      MAX_GREEN: begin
        nn = $signed({11'b0, p1_b}) - $signed({11'b0, p1_r});
        x  = dd * 19'sd60 + nn * 19'sd30;
        na = dd * 19'sd121 + nn * 19'sd60;
        nb = dd * 19'sd481 + nn * 19'sd60;
      end
      MAX_BLUE: begin
        nn = $signed({11'b0, p1_r}) - $signed({11'b0, p1_g});
        x  = dd * 19'sd120 + nn * 19'sd30;
        na = dd * 19'sd241 + nn * 19'sd60;
        nb = dd * 19'sd601 + nn * 19'sd60;
      end
      default: begin
        nn = '0;
        x  = '0;
        na = '0;
        nb = '0;
      end
    endcase

    nxt.side.b = p1_b;
    nxt.side.g = p1_g;
    nxt.side.r = p1_r;
    nxt.side.v = p1_mx;

    // black: S forced to zero via 0/1
    if (p1_mx == '0) begin
      nxt.s_num = '0;
      nxt.s_den = S_DEN_W'(1);
    end else begin
      nxt.s_num = S_NUM_W'(p1_d) * S_NUM_W'(255) + S_NUM_W'(p1_mx >> 1);
      nxt.s_den = p1_mx;
    end

    // grey: H forced to zero via 0/1
    if (p1_d == '0) begin
      nxt.h_num = '0;
      nxt.h_den = H_DEN_W'(1);
    end else begin
      nxt.h_num = x[18] ? nb[H_NUM_W-1:0] : na[H_NUM_W-1:0];
      nxt.h_den = {p1_d, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/hmcm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmcm_div: pipelined restoring divider
// Two quotient bits per stage; quotient assumed to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module hmcm_div
  import hmcm_pkg::*;
#(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  localparam int REM_W = DEN_W + QUO_W;

  logic [REM_W-1:0] rem_q [DIV_STAGES-1];
  logic [DEN_W-1:0] den_q [DIV_STAGES-1];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int K_HI = QUO_W - 1 - 2 * j;

    logic [REM_W-1:0] rem_in, sh_hi, sh_lo, rem_mid;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             bit_hi, bit_lo;

    if (j == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      sh_hi   = REM_W'(den_in) << K_HI;
      sh_lo   = REM_W'(den_in) << (K_HI - 1);
      bit_hi  = rem_in >= sh_hi;
      rem_mid = bit_hi ? rem_in - sh_hi : rem_in;
      bit_lo  = rem_mid >= sh_lo;
    end

    always_ff @(posedge clk) begin
      quo_q[j] <= {quo_in[QUO_W-3:0], bit_hi, bit_lo};
    end

    // last stage keeps no remainder
    if (j < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[j] <= bit_lo ? rem_mid - sh_lo : rem_mid;
        den_q[j] <= den_in;
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/hmcm_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmcm_match: colour window test and output register
// Four hue windows with fixed S/V floors; kept pixel passes, else zeros.
// ----------------------------------------------------------------------------
module hmcm_match
  import hmcm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [HUE_W-1:0] hue,
  input  wire logic [PIX_W-1:0] sat,
  input  wire side_t            side,
  input  wire cfg_t             cfg,
  output logic                  out_valid,
  output logic                  keep,
  output logic      [PIX_W-1:0] b_out,
  output logic      [PIX_W-1:0] g_out,
  output logic      [PIX_W-1:0] r_out
);

  logic green_hit, yellow_hit, red_hit, blue_hit, hit;

  always_comb begin
    green_hit  = hue >= cfg.green_lo && hue <= cfg.green_hi
                 && sat >= GREEN_S_MIN && side.v >= GREEN_V_MIN;
    yellow_hit = hue >= cfg.yellow_lo && hue <= cfg.yellow_hi
                 && sat >= YELLOW_S_MIN && side.v >= YELLOW_V_MIN;
    red_hit    = ((hue >= RED_BAND_ONE_FLOOR && hue <= cfg.red_one_hi)
                  || (hue >= cfg.red_two_lo && hue <= RED_BAND_TWO_CEILING))
                 && sat >= RED_S_MIN && side.v >= RED_V_MIN;
    blue_hit   = hue >= cfg.blue_lo && hue <= cfg.blue_hi
                 && sat >= BLUE_S_MIN && side.v >= BLUE_V_MIN;
    hit        = green_hit || yellow_hit || red_hit || blue_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    keep  <= hit;
    b_out <= hit ? side.b : '0;
    g_out <= hit ? side.g : '0;
    r_out <= hit ? side.r : '0;
  end

endmodule
`default_nettype wire

// ===== rtl/core/hsv_multi_color_pixel_mask.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_multi_color_pixel_mask: BGR pixel to HSV, four-colour window mask
// Converts each pixel to 8-bit HSV and keeps it if it falls in the green,
// yellow, blue or red window; other pixels come out as zeros.
// ----------------------------------------------------------------------------
//
// One pixel is taken on every clock edge where start is high; busy is tied
// low, so a new pixel may be presented every cycle. Each pixel produces one
// transaction on the result side, with done high for a single cycle, and
// results leave in the order pixels came in. The pipeline holds two
// front-end stages (max/min/chroma, then the S and H dividend/divisor pairs),
// four stages of the two pipelined dividers (two quotient bits each) and the
// window-compare output register. The receiver cannot stall: it must take
// each result in the cycle done is high. Hue windows sit in eight 8-bit
// registers written through the cfg_* channel (cfg_ready is always high);
// write them only while no pixel is in flight.
//
module hsv_multi_color_pixel_mask
  import hmcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // pixel in
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PIX_W-1:0]     blue_in,
  input  wire logic [PIX_W-1:0]     green_in,
  input  wire logic [PIX_W-1:0]     red_in,
  // result out
  output logic                      done,
  output logic                      keep_pixel,
  output logic      [PIX_W-1:0]     blue_out,
  output logic      [PIX_W-1:0]     green_out,
  output logic      [PIX_W-1:0]     red_out,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [HUE_W-1:0]     cfg_data
);

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // --------------------------------------------------------------------------
  // Hue window registers
  // --------------------------------------------------------------------------
  cfg_t cfg, cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_GREEN_LO:   cfg_next.green_lo   = cfg_data;
        REG_GREEN_HI:   cfg_next.green_hi   = cfg_data;
        REG_YELLOW_LO:  cfg_next.yellow_lo  = cfg_data;
        REG_YELLOW_HI:  cfg_next.yellow_hi  = cfg_data;
        REG_RED_ONE_HI: cfg_next.red_one_hi = cfg_data;
        REG_RED_TWO_LO: cfg_next.red_two_lo = cfg_data;
        REG_BLUE_LO:    cfg_next.blue_lo    = cfg_data;
        REG_BLUE_HI:    cfg_next.blue_hi    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

  // --------------------------------------------------------------------------
  // Front end: V, chroma, divider operands
  // --------------------------------------------------------------------------
  logic  prep_valid;
  prep_t prep;

  hmcm_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .blue      (blue_in),
    .green     (green_in),
    .red       (red_in),
    .out_valid (prep_valid),
    .out_data  (prep)
  );

  // --------------------------------------------------------------------------
  // S = round(d*255/v), H = round(x/d) with 180 folded to 0
  // --------------------------------------------------------------------------
  logic [QUO_W-1:0] s_quo, h_quo;
  logic [HUE_W-1:0] hue;

  hmcm_div #(
    .NUM_W (S_NUM_W),
    .DEN_W (S_DEN_W)
  ) u_div_s (
    .clk (clk),
    .num (prep.s_num),
    .den (prep.s_den),
    .quo (s_quo)
  );

  hmcm_div #(
    .NUM_W (H_NUM_W),
    .DEN_W (H_DEN_W)
  ) u_div_h (
    .clk (clk),
    .num (prep.h_num),
    .den (prep.h_den),
    .quo (h_quo)
  );

  // a hue that rounds up to 180 wraps round to 0
  assign hue = (h_quo >= QUO_W'(180)) ? '0 : h_quo;

  // Valid and pixel travel beside the dividers, one register per stage
  logic  [DIV_STAGES-1:0] side_valid;
  side_t                  side_q [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid <= '0;
    end else begin
      side_valid <= {side_valid[DIV_STAGES-2:0], prep_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_q[0] <= prep.side;
    for (int i = 1; i < DIV_STAGES; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Window test and result register
  // --------------------------------------------------------------------------
  hmcm_match u_match (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (side_valid[DIV_STAGES-1]),
    .hue       (hue),
    .sat       (s_quo),
    .side      (side_q[DIV_STAGES-1]),
    .cfg       (cfg),
    .out_valid (done),
    .keep      (keep_pixel),
    .b_out     (blue_out),
    .g_out     (green_out),
    .r_out     (red_out)
  );

`ifndef SYNTHESIS
  // every result traces back to a pixel that was accepted
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LATENCY))
    else $error("result without matching pixel");

  // a kept pixel comes back unchanged
  a_kept_passes: assert property (@(posedge clk) disable iff (rst)
    done && keep_pixel |-> blue_out == $past(blue_in, PIPE_LATENCY)
                           && green_out == $past(green_in, PIPE_LATENCY)
                           && red_out == $past(red_in, PIPE_LATENCY))
    else $error("kept pixel altered");

  // grey has no saturation, so it can never be kept
  a_grey_dropped: assert property (@(posedge clk) disable iff (rst)
    done && keep_pixel |-> !(red_out == green_out && green_out == blue_out))
    else $error("grey pixel kept");

  // dark input can meet no value floor
  a_dark_dropped: assert property (@(posedge clk) disable iff (rst)
    done && $past(blue_in, PIPE_LATENCY) < GREEN_V_MIN
         && $past(green_in, PIPE_LATENCY) < GREEN_V_MIN
         && $past(red_in, PIPE_LATENCY) < GREEN_V_MIN |-> !keep_pixel)
    else $error("dark pixel kept");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for hsv_multi_color_pixel_mask
// Runs a directed pixel table, then random pixels across several hue window
// settings. PREDICTED pixels are scored against an in-bench HSV mask predictor.
// ----------------------------------------------------------------------------
module tb
  import hmcm_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int PREDICTED   = -1;      // table row scored by the predictor
  localparam int N_DIRECTED  = 24;
  localparam int N_PHASES    = 10;

  // One result transaction as seen on the output ports
  typedef struct packed {
    logic             keep;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
  } mask_result_t;

  // Directed row: the pixel, plus a hand-typed keep flag or PREDICTED
  typedef struct {
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
    int               keep;
  } pixel_row_t;

  // All rows below run under the reset windows
  pixel_row_t directed_rows [N_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   0},          // black
    '{8'd255, 8'd255, 8'd255, 0},          // white, grey never kept
    '{8'd128, 8'd128, 8'd128, 0},          // mid grey
    '{8'd0,   8'd0,   8'd255, 1},          // pure red, hue 0
    '{8'd0,   8'd255, 8'd0,   1},          // pure green, hue 60
    '{8'd255, 8'd0,   8'd0,   1},          // pure blue, hue 120
    '{8'd0,   8'd255, 8'd255, 1},          // yellow, hue 30 on the window edge
    '{8'd255, 8'd0,   8'd255, 0},          // magenta, hue 150
    '{8'd255, 8'd255, 8'd0,   0},          // cyan, hue 90
    '{8'd0,   8'd0,   8'd69,  0},          // red just under the value floor
    '{8'd0,   8'd0,   8'd70,  1},          // red on the value floor
    '{8'd1,   8'd0,   8'd0,   0},          // dim blue
    '{8'd0,   8'd0,   8'd1,   0},          // dim red
    '{8'd100, 8'd140, 8'd255, PREDICTED},
    '{8'd30,  8'd200, 8'd180, PREDICTED},
    '{8'd200, 8'd60,  8'd20,  PREDICTED},
    '{8'd0,   8'd128, 8'd255, PREDICTED},
    '{8'd255, 8'd0,   8'd128, PREDICTED},  // red max loses to blue
    '{8'd40,  8'd50,  8'd60,  PREDICTED},
    '{8'd255, 8'd254, 8'd0,   PREDICTED},
    '{8'd1,   8'd255, 8'd254, PREDICTED},
    '{8'd170, 8'd85,  8'd0,   PREDICTED},
    '{8'd0,   8'd85,  8'd170, PREDICTED},
    '{8'd60,  8'd255, 8'd0,   PREDICTED}
  };

  // DUT inputs, all known from time zero
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic [PIX_W-1:0]     blue_in   = '0;
  logic [PIX_W-1:0]     green_in  = '0;
  logic [PIX_W-1:0]     red_in    = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GREEN_LO;
  logic [HUE_W-1:0]     cfg_data  = '0;

  // DUT outputs
  logic             busy;
  logic             done;
  logic             keep_pixel;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] red_out;
  logic             cfg_ready;

  // Hand-typed keep flag travelling with the pixel being presented
  int row_keep = PREDICTED;

  // Bench copy of the hue window registers, and results still owed
  cfg_t         hue_windows = CFG_RESET;
  mask_result_t pending_masks [$];
  int           error_count = 0;
  int           cycle_count = 0;

  hsv_multi_color_pixel_mask DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .blue_in    (blue_in),
    .green_in   (green_in),
    .red_in     (red_in),
    .done       (done),
    .keep_pixel (keep_pixel),
    .blue_out   (blue_out),
    .green_out  (green_out),
    .red_out    (red_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Kept pixels pass through, anything else comes out as zeros
  function automatic mask_result_t masked(input logic keep, input logic [PIX_W-1:0] b,
                                          input logic [PIX_W-1:0] g,
                                          input logic [PIX_W-1:0] r);
    mask_result_t res;
    res = keep ? mask_result_t'{1'b1, b, g, r} : mask_result_t'('0);
    return res;
  endfunction

  function automatic bit in_band(input int hue, input logic [HUE_W-1:0] lo,
                                 input logic [HUE_W-1:0] hi);
    // inverted bounds simply match nothing; bounds over 180 compare as they are
    return hue >= int'(lo) && hue <= int'(hi);
  endfunction

  // BGR -> 8-bit HSV, then the four colour windows
  function automatic mask_result_t mask_predict(input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] r,
                                                input cfg_t w);
    int  bi, gi, ri, vmax, vmin, chroma, sat, hue, num, quo;
    bit  keep_green, keep_yellow, keep_red, keep_blue;
    bi = b;
    gi = g;
    ri = r;
    vmax = bi;
    vmin = bi;
    if (gi > vmax) vmax = gi;
    if (ri > vmax) vmax = ri;
    if (gi < vmin) vmin = gi;
    if (ri < vmin) vmin = ri;
    chroma = vmax - vmin;
    // saturation rounded half up, zero for black
    sat = (vmax == 0) ? 0 : (chroma * 255 + vmax / 2) / vmax;
    if (chroma == 0) begin
      hue = 0;  // grey
    end else begin
      // hue scaled by chroma; red wins ties, then green
      if (vmax == ri)      num = 30 * (gi - bi);
      else if (vmax == gi) num = 60 * chroma + 30 * (bi - ri);
      else                 num = 120 * chroma + 30 * (ri - gi);
      if (num < 0) num += 180 * chroma;
      quo = (2 * num + chroma) / (2 * chroma);
      hue = (quo >= 180) ? 0 : quo;  // 180 wraps round to 0
    end
    keep_green  = in_band(hue, w.green_lo, w.green_hi) &&
                  sat >= int'(GREEN_S_MIN) && vmax >= int'(GREEN_V_MIN);
    keep_yellow = in_band(hue, w.yellow_lo, w.yellow_hi) &&
                  sat >= int'(YELLOW_S_MIN) && vmax >= int'(YELLOW_V_MIN);
    keep_red    = (in_band(hue, RED_BAND_ONE_FLOOR, w.red_one_hi) ||
                   in_band(hue, w.red_two_lo, RED_BAND_TWO_CEILING)) &&
                  sat >= int'(RED_S_MIN) && vmax >= int'(RED_V_MIN);
    keep_blue   = in_band(hue, w.blue_lo, w.blue_hi) &&
                  sat >= int'(BLUE_S_MIN) && vmax >= int'(BLUE_V_MIN);
    return masked(keep_green || keep_yellow || keep_red || keep_blue, b, g, r);
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: one block both retires results and books new pixels, so the
  // order between the two is fixed. Results are scored before a newly taken
  // pixel is queued.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    mask_result_t seen, want;
    if (!rst) begin
      if (done) begin
        seen = '{keep_pixel, blue_out, green_out, red_out};
        if (pending_masks.size() == 0) begin
          note_error($sformatf("unexpected result keep=%0b bgr=%0d,%0d,%0d",
                               seen.keep, seen.b, seen.g, seen.r));
        end else begin
          want = pending_masks.pop_front();
          if (seen.keep !== want.keep || seen.b !== want.b ||
              seen.g !== want.g || seen.r !== want.r)
            note_error($sformatf("keep/b/g/r expected %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
                                 want.keep, want.b, want.g, want.r,
                                 seen.keep, seen.b, seen.g, seen.r));
        end
      end
      if (start && !busy) begin
        if (row_keep != PREDICTED)
          want = masked(row_keep[0], blue_in, green_in, red_in);
        else
          want = mask_predict(blue_in, green_in, red_in, hue_windows);
        pending_masks.push_back(want);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task is entered just after a rising edge and returns on the
  // edge at which its transaction completed.
  // --------------------------------------------------------------------------

  // Present one pixel; start is left high so back-to-back pixels stream
  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r, input int keep);
    start    <= 1'b1;
    blue_in  <= b;
    green_in <= g;
    red_in   <= r;
    row_keep <= keep;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_window(input cfg_reg_t idx, input logic [HUE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GREEN_LO:   hue_windows.green_lo   = val;
      REG_GREEN_HI:   hue_windows.green_hi   = val;
      REG_YELLOW_LO:  hue_windows.yellow_lo  = val;
      REG_YELLOW_HI:  hue_windows.yellow_hi  = val;
      REG_RED_ONE_HI: hue_windows.red_one_hi = val;
      REG_RED_TWO_LO: hue_windows.red_two_lo = val;
      REG_BLUE_LO:    hue_windows.blue_lo    = val;
      REG_BLUE_HI:    hue_windows.blue_hi    = val;
      default: ;
    endcase
  endtask

  // Stop sending and let the pipeline empty; anything still owed is an error
  task automatic settle();
    int waited;
    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_masks.size() != 0 && waited < 10 * PIPE_LATENCY + 100) begin
      @(posedge clk);
      waited++;
    end
    if (pending_masks.size() != 0) begin
      note_error($sformatf("%0d results never arrived", pending_masks.size()));
      pending_masks.delete();
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Window settings per phase: zeros and all-ones for the extremes, inverted
  // windows, random sets, and the reset values written back explicitly
  task automatic program_windows(input int phase);
    logic [HUE_W-1:0] vals [8];
    for (int i = 0; i < 8; i++) begin
      case (phase)
        1:       vals[i] = 8'd0;
        2:       vals[i] = 8'd255;
        9:       vals[i] = CFG_RESET[(7 - i) * HUE_W +: HUE_W];
        default: vals[i] = (phase % 2 == 0) ? HUE_W'($urandom_range(0, 180))
                                            : HUE_W'($urandom_range(0, 255));
      endcase
    end
    if (phase == 3) begin
      // low above high in green, yellow and blue; upper red band starts past any hue
      vals[REG_GREEN_LO]   = 8'd85;  vals[REG_GREEN_HI]   = 8'd35;
      vals[REG_YELLOW_LO]  = 8'd30;  vals[REG_YELLOW_HI]  = 8'd20;
      vals[REG_RED_ONE_HI] = 8'd10;  vals[REG_RED_TWO_LO] = 8'd181;
      vals[REG_BLUE_LO]    = 8'd140; vals[REG_BLUE_HI]    = 8'd100;
    end
    for (int i = 0; i < 8; i++) write_window(cfg_reg_t'(i), vals[i]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random pixel mix: uniform, strongly coloured, grey and corner values
  task automatic random_pixel(output logic [PIX_W-1:0] b, output logic [PIX_W-1:0] g,
                              output logic [PIX_W-1:0] r);
    int pick, top, mid, low;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      b = PIX_W'($urandom);
      g = PIX_W'($urandom);
      r = PIX_W'($urandom);
    end else if (pick <= 7) begin
      // saturated colour: one high channel, one anywhere below, one low
      top = $urandom_range(30, 255);
      mid = $urandom_range(0, top);
      low = $urandom_range(0, top / 3);
      case ($urandom_range(0, 5))
        0:       begin b = PIX_W'(top); g = PIX_W'(mid); r = PIX_W'(low); end
        1:       begin b = PIX_W'(top); g = PIX_W'(low); r = PIX_W'(mid); end
        2:       begin b = PIX_W'(mid); g = PIX_W'(top); r = PIX_W'(low); end
        3:       begin b = PIX_W'(low); g = PIX_W'(top); r = PIX_W'(mid); end
        4:       begin b = PIX_W'(mid); g = PIX_W'(low); r = PIX_W'(top); end
        default: begin b = PIX_W'(low); g = PIX_W'(mid); r = PIX_W'(top); end
      endcase
    end else if (pick == 8) begin
      b = PIX_W'($urandom);
      g = b;
      r = b;
    end else begin
      b = ($urandom_range(0, 1) == 1) ? 8'd255 : PIX_W'($urandom_range(0, 1));
      g = ($urandom_range(0, 1) == 1) ? 8'd0   : PIX_W'($urandom_range(254, 255));
      r = ($urandom_range(0, 2) == 0) ? PIX_W'($urandom) : PIX_W'($urandom_range(0, 1) * 255);
    end
  endtask

  // Random pixels, with an idle gap before roughly idle_pct percent of them
  task automatic random_pixels(input int count, input int idle_pct);
    logic [PIX_W-1:0] b, g, r;
    for (int i = 0; i < count; i++) begin
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      random_pixel(b, g, r);
      send_pixel(b, g, r, PREDICTED);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset windows: directed table first, a few gaps sprinkled in, then random pixels
    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      send_pixel(directed_rows[i].b, directed_rows[i].g, directed_rows[i].r,
                 directed_rows[i].keep);
    end
    random_pixels(150, 25);
    settle();

    // Each phase reprograms every window with the pipe empty. Some phases
    // stream flat out; the last one never idles.
    for (int phase = 1; phase <= N_PHASES; phase++) begin
      program_windows(phase);
      random_pixels(172, (phase == N_PHASES || phase % 3 == 0) ? 0 : 10 + 5 * phase);
      settle();
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
